>>> hdl/vpip_pkg.sv
`timescale 1ns / 1ps

package vpip_pkg;

    // Coordinate and configuration word format (signed Q15.16).
    localparam int COORD_W   = 32;
    localparam int CFG_REGS  = 8;
    localparam int CFG_IDX_W = 3;

    // Item opcodes.
    localparam logic [1:0] OP_CLEAR  = 2'd0;
    localparam logic [1:0] OP_APPEND = 2'd1;
    localparam logic [1:0] OP_TEST   = 2'd2;

    // Configuration register indexes.
    localparam logic [CFG_IDX_W-1:0] CFG_PX_COEF_X = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_PX_COEF_Y = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_PX_COEF_Z = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_PX_OFFSET = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_PY_COEF_X = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_PY_COEF_Y = 3'd5;
    localparam logic [CFG_IDX_W-1:0] CFG_PY_COEF_Z = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_PY_OFFSET = 3'd7;

    // Projection term selector (low two bits of the projection step).
    localparam logic [1:0] TERM_X      = 2'd0;
    localparam logic [1:0] TERM_Y      = 2'd1;
    localparam logic [1:0] TERM_Z      = 2'd2;
    localparam logic [1:0] TERM_OFFSET = 2'd3;

    // Projection sequencer steps.
    localparam int          PSTEP_W     = 4;
    localparam logic [3:0]  PSTEP_FIRST = 4'd0;
    localparam logic [3:0]  PSTEP_LASTP = 4'd7;
    localparam logic [3:0]  PSTEP_XDONE = 4'd5;
    localparam logic [3:0]  PSTEP_LAST  = 4'd9;

    // Control sequencer states.
    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_PROJ = 4'b0010,
        ST_EDGE = 4'b0100,
        ST_RESP = 4'b1000
    } state_t;

endpackage

>>> hdl/vpip_item_if.sv
`timescale 1ns / 1ps

interface vpip_item_if #(
    parameter int INDEX_BITS = 10
);
    logic                                 valid;
    logic                                 ready;
    logic [1:0]                           opcode;
    logic signed [vpip_pkg::COORD_W-1:0]  vertex_x;
    logic signed [vpip_pkg::COORD_W-1:0]  vertex_y;
    logic [INDEX_BITS-1:0]                voxel_x;
    logic [INDEX_BITS-1:0]                voxel_y;
    logic [INDEX_BITS-1:0]                voxel_z;

    modport source (
        output valid, opcode, vertex_x, vertex_y, voxel_x, voxel_y, voxel_z,
        input  ready
    );

    modport sink (
        input  valid, opcode, vertex_x, vertex_y, voxel_x, voxel_y, voxel_z,
        output ready
    );
endinterface

>>> hdl/vpip_result_if.sv
`timescale 1ns / 1ps

interface vpip_result_if #(
    parameter int COUNT_BITS = 7
);
    logic                  valid;
    logic                  ready;
    logic                  inside_res;
    logic [COUNT_BITS-1:0] stored_vertices;
    logic                  store_full;

    modport source (
        output valid, inside_res, stored_vertices, store_full,
        input  ready
    );

    modport sink (
        input  valid, inside_res, stored_vertices, store_full,
        output ready
    );
endinterface

>>> hdl/vpip_ram.sv
`timescale 1ns / 1ps

module vpip_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                                     clk,
    input  logic                                     we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                         wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    // One write port and one registered read port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule

>>> hdl/voxel_point_in_polygon.sv
`timescale 1ns / 1ps

// Voxel point-in-polygon tester. Polygon vertices (signed Q15.16 plane
// coordinates) are appended one per word into a pair of vertex memories; a
// clear word empties the list and an append to a full list is dropped and
// flagged. A test word projects the voxel centre onto the plane with the two
// affine rows in the configuration registers and runs the even-odd crossing
// rule over every edge of the closed polygon. Every word returns exactly one
// result word. Clear, append and unused opcodes pass through the result state
// before the next word is taken. A test for N stored vertices runs through
// the accepting cycle, the projection steps through one shared multiplier,
// one vertex read per cycle from the vertex memories (N + 1 reads, none with
// an empty list), a drain of the read latency and the two-stage edge
// pipeline, and the result state. Backpressure on the result adds its stall
// cycles once a second word waits behind an untaken result.
// No word is taken while a test is in progress. The vertex memories need no
// initialization after reset.
module voxel_point_in_polygon #(
    parameter int MAX_VERTICES = 64,
    parameter int INDEX_BITS   = 10
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [vpip_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [vpip_pkg::COORD_W-1:0]         cfg_data,
    vpip_item_if.sink                            item,
    vpip_result_if.source                        result
);
    localparam int AW    = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW    = $clog2(MAX_VERTICES + 1);
    localparam int MW    = INDEX_BITS + 2;
    localparam int PW    = vpip_pkg::COORD_W + MW;
    localparam int ACC_W = PW + 2;
    localparam int DW    = vpip_pkg::COORD_W + 1;
    localparam int PRW   = 2 * DW;
    localparam int QW    = vpip_pkg::COORD_W;

    // Round-down halving already done; clamp to the signed coordinate range.
    function automatic logic signed [QW-1:0] sat_coord(input logic signed [ACC_W-1:0] v);
        logic [ACC_W-QW:0] upper;
        begin
            upper = v[ACC_W-1:QW-1];
            if ((&upper) || !(|upper))
            begin
                sat_coord = v[QW-1:0];
            end
            else if (v[ACC_W-1])
            begin
                sat_coord = {1'b1, {(QW-1){1'b0}}};
            end
            else
            begin
                sat_coord = {1'b0, {(QW-1){1'b1}}};
            end
        end
    endfunction

    vpip_pkg::state_t state_reg, state_next;

    logic                  item_acc;
    logic [CW-1:0]         count_reg, count_next;
    logic                  full_reg;
    logic [QW-1:0]         cfg_reg [vpip_pkg::CFG_REGS];
    logic [INDEX_BITS-1:0] vox_x_reg, vox_y_reg, vox_z_reg;

    // Projection datapath.
    logic [vpip_pkg::PSTEP_W-1:0] pstep_reg;
    logic signed [MW-1:0]         mop;
    logic signed [QW-1:0]         coef_sel;
    logic signed [PW-1:0]         prod_full;
    logic signed [PW-1:0]         prod_reg;
    logic signed [ACC_W-1:0]      acc_reg;
    logic signed [ACC_W-1:0]      acc_half;
    logic signed [QW-1:0]         px_reg, py_reg;
    logic                         acc_en, acc_start;

    // Edge walk.
    logic [CW:0]           rd_cnt_reg;
    logic                  rd_issue;
    logic [AW-1:0]         rd_addr;
    logic                  rd_vld_reg, rd_first_reg;
    logic                  ram_we;
    logic [QW-1:0]         ram_x_rd, ram_y_rd;
    logic signed [QW-1:0]  xi, yi;
    logic signed [QW-1:0]  prev_x_reg, prev_y_reg;
    logic signed [DW-1:0]  a1_reg, a2_reg, b1_reg, b2_reg;
    logic                  s1_vld_reg, s1_cond_reg;
    logic signed [PRW-1:0] pa_reg, pb_reg;
    logic                  s2_vld_reg, s2_cond_reg, s2_dypos_reg;
    logic                  edge_toggle;
    logic                  edge_done;
    logic                  inside_reg;

    // Result register.
    logic                  res_vld_reg;
    logic                  res_load;
    logic                  res_inside_reg;
    logic [CW-1:0]         res_count_reg;
    logic                  res_full_reg;

    assign item.ready = (state_reg == vpip_pkg::ST_IDLE);
    assign item_acc   = item.valid && item.ready;

    // Vertex count update and store write on an accepted word.
    always_comb
    begin
        count_next = count_reg;
        if (item_acc)
        begin
            case (item.opcode)
                vpip_pkg::OP_CLEAR:
                begin
                    count_next = '0;
                end
                vpip_pkg::OP_APPEND:
                begin
                    if (count_reg < CW'(MAX_VERTICES))
                    begin
                        count_next = count_reg + 1'b1;
                    end
                end
                default:
                begin
                    count_next = count_reg;
                end
            endcase
        end
    end

    assign ram_we = item_acc && (item.opcode == vpip_pkg::OP_APPEND)
                    && (count_reg < CW'(MAX_VERTICES));

    vpip_ram #(
        .WIDTH (QW),
        .DEPTH (MAX_VERTICES)
    ) u_ram_x (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.vertex_x),
        .raddr (rd_addr),
        .rdata (ram_x_rd)
    );

    vpip_ram #(
        .WIDTH (QW),
        .DEPTH (MAX_VERTICES)
    ) u_ram_y (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (item.vertex_y),
        .raddr (rd_addr),
        .rdata (ram_y_rd)
    );

    // Projection: one coefficient times one voxel term per step.
    always_comb
    begin
        coef_sel = cfg_reg[pstep_reg[2:0]];
        case (pstep_reg[1:0])
            vpip_pkg::TERM_X:      mop = $signed({1'b0, vox_x_reg, 1'b1});
            vpip_pkg::TERM_Y:      mop = $signed({1'b0, vox_y_reg, 1'b1});
            vpip_pkg::TERM_Z:      mop = $signed({1'b0, vox_z_reg, 1'b1});
            vpip_pkg::TERM_OFFSET: mop = MW'(2);
            default:               mop = '0;
        endcase
    end

    assign prod_full = coef_sel * mop;
    assign acc_en    = (state_reg == vpip_pkg::ST_PROJ) && (pstep_reg != vpip_pkg::PSTEP_FIRST)
                       && (pstep_reg <= (vpip_pkg::PSTEP_LASTP + 1'b1));
    assign acc_start = (pstep_reg[1:0] == 2'd1);
    assign acc_half  = acc_reg >>> 1;

    // Edge walk: read vertex N-1 first as the closing vertex, then 0 .. N-1.
    assign rd_issue = (state_reg == vpip_pkg::ST_EDGE) && ({1'b0, count_reg} >= rd_cnt_reg);
    assign rd_addr  = (rd_cnt_reg == '0) ? AW'(count_reg - 1'b1) : AW'(rd_cnt_reg - 1'b1);
    assign xi       = ram_x_rd;
    assign yi       = ram_y_rd;

    // Crossing decision: px left of the crossing, sign-corrected by dy.
    assign edge_toggle = s2_vld_reg && s2_cond_reg
                         && ((s2_dypos_reg && (pa_reg < pb_reg))
                             || (!s2_dypos_reg && (pa_reg > pb_reg)));

    assign edge_done = (state_reg == vpip_pkg::ST_EDGE) && !rd_issue && !rd_vld_reg
                       && !s1_vld_reg && !s2_vld_reg;

    assign res_load = (state_reg == vpip_pkg::ST_RESP) && (!res_vld_reg || result.ready);

    // Control sequencer.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            vpip_pkg::ST_IDLE:
            begin
                if (item_acc)
                begin
                    state_next = (item.opcode == vpip_pkg::OP_TEST) ? vpip_pkg::ST_PROJ
                                                                     : vpip_pkg::ST_RESP;
                end
            end
            vpip_pkg::ST_PROJ:
            begin
                if (pstep_reg == vpip_pkg::PSTEP_LAST)
                begin
                    state_next = (count_reg == '0) ? vpip_pkg::ST_RESP : vpip_pkg::ST_EDGE;
                end
            end
            vpip_pkg::ST_EDGE:
            begin
                if (edge_done)
                begin
                    state_next = vpip_pkg::ST_RESP;
                end
            end
            vpip_pkg::ST_RESP:
            begin
                if (res_load)
                begin
                    state_next = vpip_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = vpip_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= vpip_pkg::ST_IDLE;
            count_reg    <= '0;
            full_reg     <= 1'b0;
            pstep_reg    <= '0;
            rd_cnt_reg   <= '0;
            rd_vld_reg   <= 1'b0;
            rd_first_reg <= 1'b0;
            s1_vld_reg   <= 1'b0;
            s2_vld_reg   <= 1'b0;
            inside_reg   <= 1'b0;
            res_vld_reg  <= 1'b0;
            for (int k = 0; k < vpip_pkg::CFG_REGS; k++)
            begin
                cfg_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;

            if (cfg_we)
            begin
                cfg_reg[cfg_index] <= cfg_data;
            end

            if (item_acc)
            begin
                full_reg   <= (item.opcode == vpip_pkg::OP_APPEND)
                              && (count_reg >= CW'(MAX_VERTICES));
                inside_reg <= 1'b0;
                pstep_reg  <= '0;
            end
            else if (state_reg == vpip_pkg::ST_PROJ)
            begin
                pstep_reg <= pstep_reg + 1'b1;
            end

            if ((state_reg == vpip_pkg::ST_PROJ) && (pstep_reg == vpip_pkg::PSTEP_LAST))
            begin
                rd_cnt_reg <= '0;
            end
            else if (rd_issue)
            begin
                rd_cnt_reg <= rd_cnt_reg + 1'b1;
            end

            rd_vld_reg   <= rd_issue;
            rd_first_reg <= rd_issue && (rd_cnt_reg == '0);
            s1_vld_reg   <= rd_vld_reg && !rd_first_reg;
            s2_vld_reg   <= s1_vld_reg;

            if (edge_toggle)
            begin
                inside_reg <= !inside_reg;
            end

            if (res_load)
            begin
                res_vld_reg <= 1'b1;
            end
            else if (result.ready)
            begin
                res_vld_reg <= 1'b0;
            end
        end
    end

    // Datapath registers.
    always_ff @(posedge clk)
    begin
        if (item_acc)
        begin
            vox_x_reg <= item.voxel_x;
            vox_y_reg <= item.voxel_y;
            vox_z_reg <= item.voxel_z;
        end

        prod_reg <= prod_full;
        if (acc_en)
        begin
            acc_reg <= acc_start ? ACC_W'(prod_reg) : acc_reg + ACC_W'(prod_reg);
        end
        if ((state_reg == vpip_pkg::ST_PROJ) && (pstep_reg == vpip_pkg::PSTEP_XDONE))
        begin
            px_reg <= sat_coord(acc_half);
        end
        if ((state_reg == vpip_pkg::ST_PROJ) && (pstep_reg == vpip_pkg::PSTEP_LAST))
        begin
            py_reg <= sat_coord(acc_half);
        end

        // Stage 1: edge differences against the previous vertex.
        if (rd_vld_reg)
        begin
            prev_x_reg  <= xi;
            prev_y_reg  <= yi;
            a1_reg      <= DW'(px_reg) - DW'(xi);
            a2_reg      <= DW'(prev_y_reg) - DW'(yi);
            b1_reg      <= DW'(prev_x_reg) - DW'(xi);
            b2_reg      <= DW'(py_reg) - DW'(yi);
            s1_cond_reg <= (yi > py_reg) != (prev_y_reg > py_reg);
        end

        // Stage 2: the two cross products.
        pa_reg       <= a1_reg * a2_reg;
        pb_reg       <= b1_reg * b2_reg;
        s2_cond_reg  <= s1_cond_reg;
        s2_dypos_reg <= !a2_reg[DW-1];

        if (res_load)
        begin
            res_inside_reg <= inside_reg;
            res_count_reg  <= count_reg;
            res_full_reg   <= full_reg;
        end
    end

    assign result.valid           = res_vld_reg;
    assign result.inside_res      = res_inside_reg;
    assign result.stored_vertices = res_count_reg;
    assign result.store_full      = res_full_reg;

    // An append below capacity grows the list by one.
    assert property (@(posedge clk) disable iff (!rst_n)
        (item_acc && (item.opcode == vpip_pkg::OP_APPEND) && (count_reg < CW'(MAX_VERTICES)))
        |=> (count_reg == $past(count_reg) + 1'b1))
        else $error("vertex count did not advance on append");

    // A dropped append is only reported with a full list.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result.valid && result.store_full) |-> (result.stored_vertices == CW'(MAX_VERTICES)))
        else $error("store_full reported below capacity");

    // Vertex reads stay within the stored list.
    assert property (@(posedge clk) disable iff (!rst_n)
        rd_issue |-> ((count_reg != '0) && ({1'b0, rd_addr} < {1'b0, count_reg})))
        else $error("vertex read beyond stored list");

    // The edge pipeline is drained whenever a new word can be taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == vpip_pkg::ST_IDLE) |-> (!rd_vld_reg && !s1_vld_reg && !s2_vld_reg))
        else $error("edge pipeline busy while idle");

    // The crossing parity only moves during the edge walk or on a new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        !$stable(inside_reg) |-> (($past(state_reg) == vpip_pkg::ST_EDGE) || $past(item_acc)))
        else $error("inside flag changed outside the edge walk");
endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 1ps

module tb;

    localparam int STORE_DEPTH  = 64;
    localparam int INDEX_BITS   = 10;
    localparam int COUNT_BITS   = 7;
    localparam int RANDOM_WORDS = 850;
    localparam int QUIET_WORDS  = 110;

    localparam logic [1:0]  OP_UNUSED = 2'd3;
    localparam logic [31:0] Q_ONE     = 32'h0001_0000;
    localparam logic [31:0] Q_HALF    = 32'h0000_8000;
    localparam logic [31:0] Q_FIVE    = 32'h0005_0000;
    localparam logic [31:0] Q_TEN     = 32'h000A_0000;
    localparam logic [31:0] Q_MAXW    = 32'h7FFF_FFFF;
    localparam logic [31:0] Q_MINW    = 32'h8000_0000;
    localparam logic [31:0] ALL_ONES  = 32'hFFFF_FFFF;
    localparam logic [9:0]  TOP_INDEX = 10'd1023;
    localparam longint      SAT_HI    = 64'sh0000_0000_7FFF_FFFF;
    localparam longint      SAT_LO    = -64'sh0000_0000_8000_0000;

    // Flavors of projection setting used by the random phases.
    typedef enum int {
        KIND_GRID,
        KIND_SPREAD,
        KIND_EXTREME,
        KIND_WILD
    } phase_kind_t;

    typedef struct packed {
        logic [1:0]            op;
        logic [31:0]           vx;
        logic [31:0]           vy;
        logic [INDEX_BITS-1:0] ix;
        logic [INDEX_BITS-1:0] iy;
        logic [INDEX_BITS-1:0] iz;
    } poly_word_t;

    typedef struct packed {
        logic                  in_poly;
        logic [COUNT_BITS-1:0] count;
        logic                  full;
    } answer_t;

    // One row of the directed table; setup loads the identity projection first.
    typedef struct packed {
        logic                  setup;
        logic [7:0]            reps;
        logic [1:0]            op;
        logic [31:0]           vx;
        logic [31:0]           vy;
        logic [INDEX_BITS-1:0] ix;
        logic [INDEX_BITS-1:0] iy;
        logic [INDEX_BITS-1:0] iz;
        logic                  chk;
        logic                  in_poly;
        logic [COUNT_BITS-1:0] count;
        logic                  full;
    } row_t;

    row_t directed_rows [25] = '{
        // Reset projection: every voxel lands on the plane origin.
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd0, 1'b0},
        '{1'b0, 8'd1, OP_UNUSED, ALL_ONES, ALL_ONES, TOP_INDEX, TOP_INDEX, TOP_INDEX,
          1'b1, 1'b0, 7'd0, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_CLEAR, ALL_ONES, ALL_ONES, TOP_INDEX, TOP_INDEX,
          TOP_INDEX, 1'b1, 1'b0, 7'd0, 1'b0},
        // One and two vertices always give outside.
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd1, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, TOP_INDEX, TOP_INDEX, TOP_INDEX,
          1'b1, 1'b0, 7'd1, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, Q_MAXW, Q_MINW, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd2, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd2, 1'b0},
        // Ten by ten square under the identity projection.
        '{1'b1, 8'd1, vpip_pkg::OP_CLEAR, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd0, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd1, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, Q_TEN, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd2, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, Q_TEN, Q_TEN, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd3, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, 32'd0, Q_TEN, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd4, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd5, 10'd5, 10'd0,
          1'b1, 1'b1, 7'd4, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd0, 10'd0, TOP_INDEX,
          1'b1, 1'b1, 7'd4, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd10, 10'd5, 10'd0,
          1'b1, 1'b0, 7'd4, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd9, 10'd10, 10'd0,
          1'b1, 1'b0, 7'd4, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, TOP_INDEX, TOP_INDEX, TOP_INDEX,
          1'b1, 1'b0, 7'd4, 1'b0},
        // A far corner turns the square into a sliver; left to the predictor.
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, Q_MINW, Q_MAXW, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd5, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd3, 10'd7, 10'd5,
          1'b0, 1'b0, 7'd0, 1'b0},
        // Fill the store, then overflow it.
        '{1'b0, 8'd1, vpip_pkg::OP_CLEAR, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd0, 1'b0},
        '{1'b0, 8'd64, vpip_pkg::OP_APPEND, Q_FIVE, Q_FIVE, 10'd0, 10'd0, 10'd0,
          1'b0, 1'b0, 7'd0, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_APPEND, Q_ONE, Q_ONE, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd64, 1'b1},
        '{1'b0, 8'd1, vpip_pkg::OP_TEST, 32'd0, 32'd0, 10'd5, 10'd5, 10'd0,
          1'b1, 1'b0, 7'd64, 1'b0},
        '{1'b0, 8'd1, OP_UNUSED, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd64, 1'b0},
        '{1'b0, 8'd1, vpip_pkg::OP_CLEAR, 32'd0, 32'd0, 10'd0, 10'd0, 10'd0,
          1'b1, 1'b0, 7'd0, 1'b0}
    };

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [vpip_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [vpip_pkg::COORD_W-1:0]   cfg_data;

    vpip_item_if   #(.INDEX_BITS(INDEX_BITS)) in_words ();
    vpip_result_if #(.COUNT_BITS(COUNT_BITS)) out_words ();

    voxel_point_in_polygon #(
        .MAX_VERTICES(STORE_DEPTH),
        .INDEX_BITS  (INDEX_BITS)
    ) DUT (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .item     (in_words),
        .result   (out_words)
    );

    // Predictor state: projection rows and the polygon corner list.
    int proj_cfg [vpip_pkg::CFG_REGS];
    int corner_x [STORE_DEPTH];
    int corner_y [STORE_DEPTH];
    int corner_total;

    answer_t answers_due [$];
    int      mismatches;
    int      items_sent;
    int      gap_pct;
    int      stall_pct;

    // Clock.
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // Hard limit on the run.
    initial
    begin
        #2_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report(input string what);
        mismatches++;
        $display("[%0t] mismatch: %s", $time, what);
    endtask

    // Voxel center projected by one affine row, floored to Q15.16 and saturated.
    function automatic int project_axis(int cx, int cy, int cz, int off,
                                        logic [INDEX_BITS-1:0] ix,
                                        logic [INDEX_BITS-1:0] iy,
                                        logic [INDEX_BITS-1:0] iz);
        longint twice;
        twice = longint'(cx) * (2 * longint'(ix) + 1)
              + longint'(cy) * (2 * longint'(iy) + 1)
              + longint'(cz) * (2 * longint'(iz) + 1)
              + 2 * longint'(off);
        twice = twice >>> 1;
        if (twice > SAT_HI)
            twice = SAT_HI;
        if (twice < SAT_LO)
            twice = SAT_LO;
        return int'(twice);
    endfunction

    // Even-odd crossing count of a ray toward +x from (px, py).
    function automatic bit crossing_parity(int px, int py);
        bit                 odd;
        int                 j;
        longint             pxl, pyl, xi, yi, xj, yj, dy;
        logic signed [69:0] lhs, rhs, diff;
        odd = 1'b0;
        if (corner_total == 0)
            return 1'b0;
        pxl = px;
        pyl = py;
        j = corner_total - 1;
        for (int i = 0; i < corner_total; i++)
        begin
            xi = corner_x[i];
            yi = corner_y[i];
            xj = corner_x[j];
            yj = corner_y[j];
            if ((yi > pyl) != (yj > pyl))
            begin
                dy   = yj - yi;
                lhs  = (pxl - xi) * dy;
                rhs  = (xj - xi) * (pyl - yi);
                diff = lhs - rhs;
                if ((dy > 0 && diff < 0) || (dy < 0 && diff > 0))
                    odd = ~odd;
            end
            j = i;
        end
        return odd;
    endfunction

    // Apply one accepted word to the predictor and give its answer.
    task automatic predict_answer(input poly_word_t w, output answer_t a);
        int px, py;
        a = '0;
        case (w.op)
            vpip_pkg::OP_CLEAR:
                corner_total = 0;
            vpip_pkg::OP_APPEND:
                if (corner_total >= STORE_DEPTH)
                    a.full = 1'b1;
                else
                begin
                    corner_x[corner_total] = w.vx;
                    corner_y[corner_total] = w.vy;
                    corner_total++;
                end
            vpip_pkg::OP_TEST:
            begin
                px = project_axis(proj_cfg[vpip_pkg::CFG_PX_COEF_X],
                                  proj_cfg[vpip_pkg::CFG_PX_COEF_Y],
                                  proj_cfg[vpip_pkg::CFG_PX_COEF_Z],
                                  proj_cfg[vpip_pkg::CFG_PX_OFFSET],
                                  w.ix, w.iy, w.iz);
                py = project_axis(proj_cfg[vpip_pkg::CFG_PY_COEF_X],
                                  proj_cfg[vpip_pkg::CFG_PY_COEF_Y],
                                  proj_cfg[vpip_pkg::CFG_PY_COEF_Z],
                                  proj_cfg[vpip_pkg::CFG_PY_OFFSET],
                                  w.ix, w.iy, w.iz);
                a.in_poly = crossing_parity(px, py);
            end
            default:
                ;
        endcase
        a.count = corner_total[COUNT_BITS-1:0];
    endtask

    // Offer one word (called at a falling edge, returns at a falling edge).
    task automatic send_word(input poly_word_t w, input bit chk, input answer_t typed);
        answer_t a;
        if ($urandom_range(0, 99) < gap_pct)
        begin
            in_words.valid = 1'b0;
            repeat ($urandom_range(1, 14)) @(negedge clk);
        end
        in_words.valid    = 1'b1;
        in_words.opcode   = w.op;
        in_words.vertex_x = w.vx;
        in_words.vertex_y = w.vy;
        in_words.voxel_x  = w.ix;
        in_words.voxel_y  = w.iy;
        in_words.voxel_z  = w.iz;
        do
            @(posedge clk);
        while (!in_words.ready);
        predict_answer(w, a);
        answers_due.push_back(chk ? typed : a);
        if (w.op != OP_UNUSED)
            items_sent++;
        @(negedge clk);
    endtask

    // Wait until every answer is back and the block is idle again.
    task automatic settle();
        in_words.valid = 1'b0;
        while (answers_due.size() != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
    endtask

    task automatic write_reg(input logic [vpip_pkg::CFG_IDX_W-1:0] idx,
                             input logic [31:0] value);
        cfg_we    = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        proj_cfg[idx] = value;
        @(negedge clk);
        cfg_we = 1'b0;
    endtask

    task automatic load_projection(input logic [31:0] xx, xy, xz, xo, yx, yy, yz, yo);
        write_reg(vpip_pkg::CFG_PX_COEF_X, xx);
        write_reg(vpip_pkg::CFG_PX_COEF_Y, xy);
        write_reg(vpip_pkg::CFG_PX_COEF_Z, xz);
        write_reg(vpip_pkg::CFG_PX_OFFSET, xo);
        write_reg(vpip_pkg::CFG_PY_COEF_X, yx);
        write_reg(vpip_pkg::CFG_PY_COEF_Y, yy);
        write_reg(vpip_pkg::CFG_PY_COEF_Z, yz);
        write_reg(vpip_pkg::CFG_PY_OFFSET, yo);
    endtask

    // Register value for extreme phases; the slot rotates min and max over registers.
    function automatic logic [31:0] extreme_word(int slot);
        if (slot % 3 == 0)
            return Q_MINW;
        if (slot % 3 == 1)
            return Q_MAXW;
        case ($urandom_range(0, 3))
            0:       return 32'd0;
            1:       return 32'd1;
            2:       return ALL_ONES;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [31:0] pick_coord(phase_kind_t kind);
        case (kind)
            KIND_GRID:   return 32'($urandom_range(0, 40)) << 15;
            KIND_SPREAD: return $urandom_range(0, 32'h4000_0000) - 32'h2000_0000;
            KIND_EXTREME:
                case ($urandom_range(0, 3))
                    0:       return Q_MAXW;
                    1:       return Q_MINW;
                    2:       return 32'd0;
                    default: return $urandom;
                endcase
            default:     return $urandom;
        endcase
    endfunction

    function automatic poly_word_t make_word(logic [1:0] op, phase_kind_t kind);
        poly_word_t w;
        w.op = op;
        w.vx = pick_coord(kind);
        w.vy = pick_coord(kind);
        if (kind == KIND_GRID)
        begin
            w.ix = INDEX_BITS'($urandom_range(0, 20));
            w.iy = INDEX_BITS'($urandom_range(0, 20));
            w.iz = INDEX_BITS'($urandom_range(0, 20));
        end
        else
        begin
            w.ix = INDEX_BITS'($urandom);
            w.iy = INDEX_BITS'($urandom);
            w.iz = INDEX_BITS'($urandom);
        end
        return w;
    endfunction

    // Program the projection rows for a phase.
    task automatic enter_phase(input phase_kind_t kind, input int phase);
        settle();
        case (kind)
            KIND_GRID:
                load_projection(Q_ONE, 32'd0, $urandom_range(0, 1) ? Q_HALF : 32'd0,
                                $urandom_range(0, 1) ? -Q_HALF : 32'd0,
                                32'd0, Q_ONE, $urandom_range(0, 1) ? Q_HALF : 32'd0,
                                $urandom_range(0, 1) ? -Q_HALF : 32'd0);
            KIND_SPREAD:
                load_projection($urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h2000_0000) - 32'h1000_0000,
                                $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h0004_0000) - 32'h0002_0000,
                                $urandom_range(0, 32'h2000_0000) - 32'h1000_0000);
            KIND_EXTREME:
                load_projection(extreme_word(phase), extreme_word(phase + 1),
                                extreme_word(phase + 2), extreme_word(phase + 3),
                                extreme_word(phase + 4), extreme_word(phase + 5),
                                extreme_word(phase + 6), extreme_word(phase + 7));
            default:
                load_projection($urandom, $urandom, $urandom, $urandom,
                                $urandom, $urandom, $urandom, $urandom);
        endcase
    endtask

    // Mostly whole polygons followed by tests; the rest is loose noise words.
    task automatic run_phase(input phase_kind_t kind, input int budget);
        int start, corners, tests, roll;
        start = items_sent;
        while (items_sent - start < budget)
        begin
            if ($urandom_range(0, 99) < 85)
            begin
                send_word(make_word(vpip_pkg::OP_CLEAR, kind), 1'b0, '0);
                roll = $urandom_range(0, 99);
                if (roll < 8)
                    corners = $urandom_range(0, 2);
                else if (roll < 97)
                    corners = $urandom_range(3, 10);
                else
                    corners = $urandom_range(60, 68);
                repeat (corners) send_word(make_word(vpip_pkg::OP_APPEND, kind), 1'b0, '0);
                tests = $urandom_range(2, 8);
                repeat (tests) send_word(make_word(vpip_pkg::OP_TEST, kind), 1'b0, '0);
            end
            else
                send_word(make_word(2'($urandom_range(0, 3)), KIND_WILD), 1'b0, '0);
        end
    endtask

    // Result side: random backpressure in bursts.
    initial
    begin
        out_words.ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if ($urandom_range(0, 99) < stall_pct)
            begin
                out_words.ready = 1'b0;
                repeat ($urandom_range(1, 14)) @(negedge clk);
            end
            out_words.ready = 1'b1;
        end
    end

    // Compare each accepted result word with the oldest pending answer.
    always @(posedge clk)
    begin
        answer_t want;
        if (rst_n && out_words.valid && out_words.ready)
        begin
            if (answers_due.size() == 0)
                report("result word arrived with no answer pending");
            else
            begin
                want = answers_due.pop_front();
                if (out_words.inside_res !== want.in_poly)
                    report($sformatf("inside_res %b, predicted %b",
                                     out_words.inside_res, want.in_poly));
                if (out_words.stored_vertices !== want.count)
                    report($sformatf("stored_vertices %0d, predicted %0d",
                                     out_words.stored_vertices, want.count));
                if (out_words.store_full !== want.full)
                    report($sformatf("store_full %b, predicted %b",
                                     out_words.store_full, want.full));
            end
        end
    end

    // Main sequence: reset, directed table, random phases, drain.
    initial
    begin
        poly_word_t  w;
        answer_t     typed;
        phase_kind_t kind;
        int          phase;
        int          random_start;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_data          = '0;
        in_words.valid    = 1'b0;
        in_words.opcode   = vpip_pkg::OP_CLEAR;
        in_words.vertex_x = '0;
        in_words.vertex_y = '0;
        in_words.voxel_x  = '0;
        in_words.voxel_y  = '0;
        in_words.voxel_z  = '0;
        mismatches        = 0;
        items_sent        = 0;
        corner_total      = 0;
        gap_pct           = 15;
        stall_pct         = 15;
        foreach (proj_cfg[k])
            proj_cfg[k] = 0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        // Directed table.
        foreach (directed_rows[r])
        begin
            if (directed_rows[r].setup)
            begin
                settle();
                load_projection(Q_ONE, 32'd0, 32'd0, 32'd0, 32'd0, Q_ONE, 32'd0, 32'd0);
            end
            w     = '{directed_rows[r].op, directed_rows[r].vx, directed_rows[r].vy,
                      directed_rows[r].ix, directed_rows[r].iy, directed_rows[r].iz};
            typed = '{directed_rows[r].in_poly, directed_rows[r].count,
                      directed_rows[r].full};
            repeat (directed_rows[r].reps) send_word(w, directed_rows[r].chk, typed);
        end

        // Random phases with idling on both sides.
        phase        = 0;
        random_start = items_sent;
        while (items_sent - random_start < RANDOM_WORDS - QUIET_WORDS)
        begin
            kind = phase_kind_t'(phase % 4);
            enter_phase(kind, phase);
            gap_pct   = 12 * $urandom_range(0, 2);
            stall_pct = 12 * $urandom_range(0, 2);
            run_phase(kind, 110);
            phase++;
        end

        // The final stretch runs without any idling.
        kind = phase_kind_t'(phase % 4);
        enter_phase(kind, phase);
        gap_pct   = 0;
        stall_pct = 0;
        run_phase(kind, QUIET_WORDS);

        settle();
        repeat (40) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
